@@ rtl/tss_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constants of the temperature sensor supervisor.
package tss_pkg;

  // Configuration port geometry
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_LOW_LIMIT       = 3'd0;
  localparam logic [2:0] REG_HIGH_LIMIT      = 3'd1;
  localparam logic [2:0] REG_STALE_TIMEOUT   = 3'd2;
  localparam logic [2:0] REG_POWER_OFF_TIME  = 3'd3;
  localparam logic [2:0] REG_POWER_ON_SETTLE = 3'd4;

  // Register reset values
  localparam logic [11:0] LOW_LIMIT_RST       = 12'(-880);
  localparam logic [11:0] HIGH_LIMIT_RST      = 12'd1360;
  localparam logic [31:0] STALE_TIMEOUT_RST   = 32'd60000;
  localparam logic [15:0] POWER_OFF_TIME_RST  = 16'd1000;
  localparam logic [15:0] POWER_ON_SETTLE_RST = 16'd500;

  // Item kinds
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_DETECT = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_NOSENSOR = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  // Special temperature codes, 1/16 degree
  localparam logic [11:0] DISCONNECT_CODE = 12'(-2032);
  localparam logic [14:0] NO_SENSOR_CODE  = 15'(-15984);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_OFF    = 2'd1,
    PH_SETTLE = 2'd2
  } phase_t;

  typedef struct packed {
    logic [11:0] low_limit;
    logic [11:0] high_limit;
    logic [31:0] stale_timeout;
    logic [15:0] power_off_time;
    logic [15:0] power_on_settle;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  restart_phase;
    logic        detect_request;
    logic        power_enable;
    logic [1:0]  status;
    logic [14:0] temp_value;
  } res_t;

endpackage

@@ rtl/tss_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file with its APB-style access port.
module tss_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tss_pkg::CFG_AW-1:0]  paddr,
  input  logic [tss_pkg::CFG_DW-1:0]  pwdata,
  output logic [tss_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output tss_pkg::cfg_t               cfg
);

  tss_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[tss_pkg::CFG_AW-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_limit       <= tss_pkg::LOW_LIMIT_RST;
      cfg_r.high_limit      <= tss_pkg::HIGH_LIMIT_RST;
      cfg_r.stale_timeout   <= tss_pkg::STALE_TIMEOUT_RST;
      cfg_r.power_off_time  <= tss_pkg::POWER_OFF_TIME_RST;
      cfg_r.power_on_settle <= tss_pkg::POWER_ON_SETTLE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        tss_pkg::REG_LOW_LIMIT:       cfg_r.low_limit       <= pwdata[11:0];
        tss_pkg::REG_HIGH_LIMIT:      cfg_r.high_limit      <= pwdata[11:0];
        tss_pkg::REG_STALE_TIMEOUT:   cfg_r.stale_timeout   <= pwdata[31:0];
        tss_pkg::REG_POWER_OFF_TIME:  cfg_r.power_off_time  <= pwdata[15:0];
        tss_pkg::REG_POWER_ON_SETTLE: cfg_r.power_on_settle <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tss_pkg::REG_LOW_LIMIT:       prdata = {{20{cfg_r.low_limit[11]}}, cfg_r.low_limit};
      tss_pkg::REG_HIGH_LIMIT:      prdata = {{20{cfg_r.high_limit[11]}}, cfg_r.high_limit};
      tss_pkg::REG_STALE_TIMEOUT:   prdata = cfg_r.stale_timeout;
      tss_pkg::REG_POWER_OFF_TIME:  prdata = {16'd0, cfg_r.power_off_time};
      tss_pkg::REG_POWER_ON_SETTLE: prdata = {16'd0, cfg_r.power_on_settle};
      default:                      prdata = '0;
    endcase
  end

endmodule

@@ rtl/tss_core.sv @@
`timescale 1ns / 1ps
// Supervisor state and the single-pass update that produces one result per item.
module tss_core (
  input  logic           clk,
  input  logic           rst_n,
  input  tss_pkg::cfg_t  cfg,
  input  logic           step_en,
  input  logic [1:0]     opcode,
  input  logic [11:0]    temp_sample,
  input  logic           sensor_present,
  output tss_pkg::res_t  res
);

  tss_pkg::phase_t phase_r, phase_nxt;
  logic            found_r, found_nxt;
  logic [11:0]     last_r, last_nxt;
  logic [31:0]     stale_r, stale_nxt;
  logic [15:0]     pcnt_r, pcnt_nxt;
  logic            power_r, power_nxt;
  logic            detect;
  logic            sample_bad;

  assign sample_bad = (temp_sample == tss_pkg::DISCONNECT_CODE) ||
                      ($signed(temp_sample) < $signed(cfg.low_limit)) ||
                      ($signed(temp_sample) > $signed(cfg.high_limit));

  always_comb begin
    phase_nxt      = phase_r;
    found_nxt      = found_r;
    last_nxt       = last_r;
    stale_nxt      = stale_r;
    pcnt_nxt       = pcnt_r;
    power_nxt      = power_r;
    detect         = 1'b0;
    res.temp_value = '0;
    res.status     = tss_pkg::ST_NONE;

    unique case (opcode)
      tss_pkg::OP_TICK: begin
        // saturate the staleness count
        stale_nxt = (&stale_r) ? stale_r : stale_r + 32'd1;
        unique case (phase_r)
          tss_pkg::PH_OFF: begin
            if (pcnt_r >= cfg.power_off_time) begin
              power_nxt = 1'b1;
              pcnt_nxt  = '0;
              phase_nxt = tss_pkg::PH_SETTLE;
            end else begin
              pcnt_nxt = pcnt_r + 16'd1;
            end
          end
          tss_pkg::PH_SETTLE: begin
            if (pcnt_r >= cfg.power_on_settle) begin
              stale_nxt = '0;
              detect    = 1'b1;
              phase_nxt = tss_pkg::PH_IDLE;
            end else begin
              pcnt_nxt = pcnt_r + 16'd1;
            end
          end
          default: begin
            // compare the count before this tick
            phase_nxt = tss_pkg::PH_IDLE;
            if (stale_r >= cfg.stale_timeout) begin
              power_nxt = 1'b0;
              pcnt_nxt  = '0;
              phase_nxt = tss_pkg::PH_OFF;
            end
          end
        endcase
      end
      tss_pkg::OP_READ: begin
        priority if (!found_r) begin
          res.temp_value = tss_pkg::NO_SENSOR_CODE;
          res.status     = tss_pkg::ST_NOSENSOR;
        end else if (sample_bad) begin
          res.temp_value = {{3{last_r[11]}}, last_r};
          res.status     = tss_pkg::ST_INVALID;
        end else begin
          if (temp_sample != last_r) begin
            last_nxt  = temp_sample;
            stale_nxt = '0;
          end
          res.temp_value = {{3{temp_sample[11]}}, temp_sample};
          res.status     = tss_pkg::ST_VALID;
        end
      end
      tss_pkg::OP_DETECT: found_nxt = sensor_present;
      default: ;
    endcase

    res.power_enable   = power_nxt;
    res.detect_request = detect;
    res.restart_phase  = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tss_pkg::PH_IDLE;
      found_r <= 1'b0;
      last_r  <= '0;
      stale_r <= '0;
      pcnt_r  <= '0;
      power_r <= 1'b1;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      found_r <= found_nxt;
      last_r  <= last_nxt;
      stale_r <= stale_nxt;
      pcnt_r  <= pcnt_nxt;
      power_r <= power_nxt;
    end
  end

endmodule

@@ rtl/temp_sensor_supervisor.sv @@
`timescale 1ns / 1ps
// Path: an accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while the output does not stall; the supervisor state is read and written in one pass.
// Reset (rst_n low at a clock edge): both stages empty, restart phase idle, power on,
// no sensor found, last valid value and counters zero, registers at their defaults.
// Top level of the temperature sensor supervisor.
module temp_sensor_supervisor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // temp_sample[11:0], sensor_present[12]
  input  logic [1:0]                  in_tuser,   // opcode[1:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // temp_value[14:0], power_enable[15], detect_request[16], restart_phase[18:17]
  output logic [23:0]                 out_tdata,
  output logic [1:0]                  out_tuser,  // status[1:0]
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tss_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [tss_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [tss_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  tss_pkg::cfg_t cfg;
  tss_pkg::res_t res;
  tss_pkg::res_t res_r;

  logic        s1_valid_r;
  logic [1:0]  s1_opcode_r;
  logic [11:0] s1_sample_r;
  logic        s1_present_r;
  logic        out_valid_r;
  logic        advance;
  logic        in_xfer;

  assign advance   = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | advance;
  assign in_xfer   = in_tvalid & in_tready;

  tss_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  tss_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .step_en        (advance),
    .opcode         (s1_opcode_r),
    .temp_sample    (s1_sample_r),
    .sensor_present (s1_present_r),
    .res            (res)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_opcode_r  <= in_tuser;
      s1_sample_r  <= in_tdata[11:0];
      s1_present_r <= in_tdata[12];
    end
  end

  // result stage: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {5'd0, res_r.restart_phase, res_r.detect_request,
                       res_r.power_enable, res_r.temp_value};

`ifndef ASSERT_OFF
  a_detect_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.detect_request |-> res_r.restart_phase == tss_pkg::PH_IDLE)
    else $error("re-detection request outside idle phase");

  a_off_unpowered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.restart_phase == tss_pkg::PH_OFF) |-> !res_r.power_enable)
    else $error("power on during power-off phase");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |-> !in_tready && !advance)
    else $error("input taken while both stages are full");

  a_status_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.status == tss_pkg::ST_NONE) |-> res_r.temp_value == '0)
    else $error("non-reading result carries a temperature");
`endif

endmodule

@@ sim/temp_sensor_supervisor_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the temperature sensor supervisor: directed rows, then random phases.
module temp_sensor_supervisor_tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEMS_PER_SET = 125;

  typedef struct packed {
    logic [14:0]      temp;
    logic [1:0]       status;
    logic             power;
    logic             detect;
    tss_pkg::phase_t  phase;
  } sup_result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] smp;
    logic        pres;
    logic        typed;
    logic [14:0] temp;
    logic [1:0]  status;
  } stim_row_t;

  typedef struct packed {
    logic [11:0] lo;
    logic [11:0] hi;
    logic [31:0] timeout;
    logic [15:0] off;
    logic [15:0] settle;
    logic [7:0]  tick_pct;
    logic [7:0]  read_pct;
  } cfg_set_t;

  // Opening rows run at the reset defaults (-880 .. 1360).
  localparam stim_row_t DIR_ROWS [22] = '{
    '{tss_pkg::OP_READ, 12'd100, 1'b0, 1'b1, tss_pkg::NO_SENSOR_CODE, tss_pkg::ST_NOSENSOR},
    '{tss_pkg::OP_TICK, 12'd0, 1'b0, 1'b1, 15'd0, tss_pkg::ST_NONE},
    '{OP_UNUSED, 12'hFFF, 1'b1, 1'b1, 15'd0, tss_pkg::ST_NONE},
    '{tss_pkg::OP_DETECT, 12'd0, 1'b0, 1'b1, 15'd0, tss_pkg::ST_NONE},
    '{tss_pkg::OP_READ, 12'd0, 1'b1, 1'b1, tss_pkg::NO_SENSOR_CODE, tss_pkg::ST_NOSENSOR},
    '{tss_pkg::OP_DETECT, 12'd0, 1'b1, 1'b1, 15'd0, tss_pkg::ST_NONE},
    '{tss_pkg::OP_READ, tss_pkg::DISCONNECT_CODE, 1'b0, 1'b1, 15'd0, tss_pkg::ST_INVALID},
    '{tss_pkg::OP_READ, 12'h7FF, 1'b0, 1'b1, 15'd0, tss_pkg::ST_INVALID},
    '{tss_pkg::OP_READ, 12'h800, 1'b1, 1'b1, 15'd0, tss_pkg::ST_INVALID},
    '{tss_pkg::OP_READ, 12'd1360, 1'b0, 1'b1, 15'd1360, tss_pkg::ST_VALID},
    '{tss_pkg::OP_READ, 12'd1361, 1'b0, 1'b1, 15'd1360, tss_pkg::ST_INVALID},
    '{tss_pkg::OP_READ, 12'(-880), 1'b0, 1'b1, 15'(-880), tss_pkg::ST_VALID},
    '{tss_pkg::OP_READ, 12'(-881), 1'b0, 1'b1, 15'(-880), tss_pkg::ST_INVALID},
    '{tss_pkg::OP_READ, 12'(-880), 1'b1, 1'b1, 15'(-880), tss_pkg::ST_VALID},
    '{tss_pkg::OP_TICK, 12'hABC, 1'b1, 1'b0, 15'd0, tss_pkg::ST_NONE},
    '{tss_pkg::OP_READ, 12'd0, 1'b0, 1'b1, 15'd0, tss_pkg::ST_VALID},
    '{tss_pkg::OP_READ, 12'h555, 1'b0, 1'b0, 15'd0, tss_pkg::ST_NONE},
    '{tss_pkg::OP_READ, 12'hAAA, 1'b1, 1'b0, 15'd0, tss_pkg::ST_NONE},
    '{tss_pkg::OP_TICK, 12'd0, 1'b0, 1'b0, 15'd0, tss_pkg::ST_NONE},
    '{tss_pkg::OP_DETECT, 12'hFFF, 1'b0, 1'b1, 15'd0, tss_pkg::ST_NONE},
    '{tss_pkg::OP_READ, 12'd5, 1'b1, 1'b1, tss_pkg::NO_SENSOR_CODE, tss_pkg::ST_NOSENSOR},
    '{tss_pkg::OP_DETECT, 12'd0, 1'b1, 1'b0, 15'd0, tss_pkg::ST_NONE}
  };

  localparam cfg_set_t CFG_SETS [6] = '{
    '{12'h800,    12'h7FF,    32'd0,        16'd0,    16'd0,    8'd60, 8'd30},
    '{12'(-500),  12'd500,    32'd20,       16'd5,    16'd3,    8'd80, 8'd12},
    '{12'd100,    12'(-100),  32'd3,        16'd2,    16'd1,    8'd50, 8'd35},
    '{12'h800,    12'h7FF,    32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 8'd45, 8'd40},
    '{12'h7FF,    12'h800,    32'd10,       16'hFFFF, 16'd0,    8'd60, 8'd25},
    '{12'(-880),  12'd1360,   32'd40,       16'd8,    16'd6,    8'd85, 8'd8}
  };

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [15:0]                 in_tdata = '0;   // temp_sample[11:0], sensor_present[12]
  logic [1:0]                  in_tuser = '0;   // opcode[1:0]
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  // temp_value[14:0], power_enable[15], detect_request[16], restart_phase[18:17]
  logic [23:0]                 out_tdata;
  logic [1:0]                  out_tuser;       // status[1:0]
  logic                        cfg_psel = 1'b0;
  logic                        cfg_penable = 1'b0;
  logic                        cfg_pwrite = 1'b0;
  logic [tss_pkg::CFG_AW-1:0]  cfg_paddr = '0;
  logic [tss_pkg::CFG_DW-1:0]  cfg_pwdata = '0;
  logic [tss_pkg::CFG_DW-1:0]  cfg_prdata;
  logic                        cfg_pready;

  // Supervisor shadow: configuration and state.
  logic signed [11:0]  lo_lim = tss_pkg::LOW_LIMIT_RST;
  logic signed [11:0]  hi_lim = tss_pkg::HIGH_LIMIT_RST;
  logic [31:0]         stale_limit = tss_pkg::STALE_TIMEOUT_RST;
  logic [15:0]         off_ticks = tss_pkg::POWER_OFF_TIME_RST;
  logic [15:0]         settle_ticks = tss_pkg::POWER_ON_SETTLE_RST;
  tss_pkg::phase_t     rst_phase = tss_pkg::PH_IDLE;
  logic                found = 1'b0;
  logic signed [11:0]  last_good = '0;
  logic [31:0]         stale_cnt = '0;
  logic [15:0]         phase_cnt = '0;
  logic                pwr_on = 1'b1;

  sup_result_t         awaited [$];
  int                  err_count = 0;
  int                  rx_count = 0;
  int                  burst_left = 0;
  logic                hold_rx = 1'b0;
  int                  rx_mode = 0;
  int                  rx_mode_left = 0;

  temp_sensor_supervisor uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic sup_result_t supervisor_step(logic [1:0] op, logic signed [11:0] smp,
                                                  logic pres);
    sup_result_t r;
    logic [31:0] prev;
    r.temp = '0;
    r.status = tss_pkg::ST_NONE;
    r.detect = 1'b0;
    case (op)
      tss_pkg::OP_TICK: begin
        prev = stale_cnt;
        if (stale_cnt != '1) stale_cnt = stale_cnt + 32'd1;
        case (rst_phase)
          tss_pkg::PH_OFF: begin
            if (phase_cnt >= off_ticks) begin
              pwr_on = 1'b1;
              phase_cnt = '0;
              rst_phase = tss_pkg::PH_SETTLE;
            end else begin
              phase_cnt = phase_cnt + 16'd1;
            end
          end
          tss_pkg::PH_SETTLE: begin
            if (phase_cnt >= settle_ticks) begin
              stale_cnt = '0;
              r.detect = 1'b1;
              rst_phase = tss_pkg::PH_IDLE;
            end else begin
              phase_cnt = phase_cnt + 16'd1;
            end
          end
          default: begin
            // compare the count from before this tick
            if (prev >= stale_limit) begin
              pwr_on = 1'b0;
              phase_cnt = '0;
              rst_phase = tss_pkg::PH_OFF;
            end
          end
        endcase
      end
      tss_pkg::OP_READ: begin
        if (!found) begin
          r.temp = tss_pkg::NO_SENSOR_CODE;
          r.status = tss_pkg::ST_NOSENSOR;
        end else if (smp == tss_pkg::DISCONNECT_CODE || smp < lo_lim || smp > hi_lim) begin
          r.temp = 15'(last_good);
          r.status = tss_pkg::ST_INVALID;
        end else begin
          if (smp != last_good) begin
            last_good = smp;
            stale_cnt = '0;
          end
          r.temp = 15'(smp);
          r.status = tss_pkg::ST_VALID;
        end
      end
      tss_pkg::OP_DETECT: found = pres;
      default: ;
    endcase
    r.power = pwr_on;
    r.phase = rst_phase;
    return r;
  endfunction

  function automatic logic [11:0] pick_sample();
    int lo;
    int hi;
    lo = int'(lo_lim);
    hi = int'(hi_lim);
    case ($urandom_range(0, 9))
      0: return tss_pkg::DISCONNECT_CODE;
      1: return $urandom_range(0, 1) ? 12'h7FF : 12'h800;
      2: return lo_lim;
      3: return hi_lim;
      4, 5: return last_good;
      6: return 12'($urandom);
      default: begin
        if (lo <= hi) return 12'(lo + int'($urandom_range(0, hi - lo)));
        return 12'($urandom);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (err_count < 200)
      $display("mismatch %s: got %0h, want %0h (result %0d, t=%0t)", what, got, want,
               rx_count, $realtime);
    err_count++;
  endtask

  // Hold valid and data until the transfer, then queue the prediction.
  task automatic send_item(logic [1:0] op, logic [11:0] smp, logic pres, logic typed,
                           logic [14:0] t_temp, logic [1:0] t_stat);
    int gap;
    sup_result_t want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {3'b000, pres, smp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = supervisor_step(op, smp, pres);
    if (typed) begin
      want.temp = t_temp;
      want.status = t_stat;
    end
    awaited.push_back(want);
  endtask

  task automatic drain();
    while (awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // psel stays high across back-to-back writes; the caller drops it.
  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= tss_pkg::CFG_AW'({idx, 2'b00});
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_penable <= 1'b0;
    case (idx)
      tss_pkg::REG_LOW_LIMIT:       lo_lim = val[11:0];
      tss_pkg::REG_HIGH_LIMIT:      hi_lim = val[11:0];
      tss_pkg::REG_STALE_TIMEOUT:   stale_limit = val;
      tss_pkg::REG_POWER_OFF_TIME:  off_ticks = val[15:0];
      tss_pkg::REG_POWER_ON_SETTLE: settle_ticks = val[15:0];
      default: ;
    endcase
  endtask

  task automatic run_random_set(cfg_set_t cs);
    int done;
    int r;
    logic [1:0] op;
    logic [11:0] smp;
    logic pres;
    cfg_write(tss_pkg::REG_LOW_LIMIT, {{20{cs.lo[11]}}, cs.lo});
    cfg_write(tss_pkg::REG_HIGH_LIMIT, {{20{cs.hi[11]}}, cs.hi});
    cfg_write(tss_pkg::REG_STALE_TIMEOUT, cs.timeout);
    cfg_write(tss_pkg::REG_POWER_OFF_TIME, {16'd0, cs.off});
    cfg_write(tss_pkg::REG_POWER_ON_SETTLE, {16'd0, cs.settle});
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_pwrite <= 1'b0;
    done = 0;
    while (done < ITEMS_PER_SET) begin
      r = $urandom_range(0, 99);
      smp = 12'($urandom);
      pres = 1'($urandom);
      if (r < cs.tick_pct) begin
        op = tss_pkg::OP_TICK;
      end else if (r < cs.tick_pct + cs.read_pct) begin
        op = tss_pkg::OP_READ;
        smp = pick_sample();
      end else if (r < 96) begin
        op = tss_pkg::OP_DETECT;
        pres = ($urandom_range(0, 5) != 0);
      end else begin
        op = OP_UNUSED;
      end
      if (op != OP_UNUSED) done++;
      send_item(op, smp, pres, 1'b0, 15'd0, tss_pkg::ST_NONE);
    end
    in_tvalid <= 1'b0;
    drain();
  endtask

  // Receiver: ready pattern switches between always-ready, random and mostly-stalled modes.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_mode_left <= $urandom_range(16, 96);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    if (hold_rx) out_tready <= 1'b0;
    else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Long receiver stall so the pipeline fills and backs up the input.
  initial begin
    wait (rx_count >= 300);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (80) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    sup_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      rx_count++;
      if (awaited.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 0);
      end else begin
        want = awaited.pop_front();
        if (out_tdata[14:0] !== want.temp)
          report_mismatch("temp_value", out_tdata[14:0], want.temp);
        if (out_tuser !== want.status)
          report_mismatch("status", out_tuser, want.status);
        if (out_tdata[15] !== want.power)
          report_mismatch("power_enable", out_tdata[15], want.power);
        if (out_tdata[16] !== want.detect)
          report_mismatch("detect_request", out_tdata[16], want.detect);
        if (out_tdata[18:17] !== want.phase)
          report_mismatch("restart_phase", out_tdata[18:17], want.phase);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DIR_ROWS[i])
      send_item(DIR_ROWS[i].op, DIR_ROWS[i].smp, DIR_ROWS[i].pres, DIR_ROWS[i].typed,
                DIR_ROWS[i].temp, DIR_ROWS[i].status);
    in_tvalid <= 1'b0;
    drain();
    foreach (CFG_SETS[i]) run_random_set(CFG_SETS[i]);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tss_pkg.sv
rtl/tss_cfg_regs.sv
rtl/tss_core.sv
rtl/temp_sensor_supervisor.sv
sim/temp_sensor_supervisor_tb.sv
